// ===== hw/rtl/inr_pkg.sv =====
// shared constants and types for the integer nth root block
package inr_pkg;

    localparam int VALUE_BITS = 32;
    localparam int BIT_W      = $clog2(VALUE_BITS);
    localparam int EXP_W      = 6;
    localparam int ROOT_W     = 32;
    localparam int IN_DATA_W  = ((ROOT_W + EXP_W + 7) / 8) * 8;
    localparam int PROD_W     = 2 * VALUE_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_NEXT,
        ST_FINISH
    } inr_state_t;

endpackage

// ===== hw/rtl/integer_nth_root_top.sv =====
// integer nth root: bitwise root search over one shared multiplier
// a zero exponent or one of VALUE_BITS and above skips the search; otherwise each root bit
//   runs k multiply and compare rounds, k at most the exponent, then a step to the next bit
// throughput: one item at a time; the shared multiply and compare loop sets the pace
// the next item is accepted while a finished result still waits in the output register
// reset: rst_n is asynchronous, active low; it drops all valid flags and returns to idle
module integer_nth_root_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [inr_pkg::IN_DATA_W-1:0] s_axis_tdata,  // value[31:0], exponent[37:32], zero pad
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [inr_pkg::ROOT_W-1:0]    m_axis_tdata,  // root[31:0]
    output logic                          m_axis_tuser   // bad_exponent
);
    import inr_pkg::*;

    // sequencer state
    inr_state_t state_reg, state_next;

    // working registers of the search
    logic [VALUE_BITS-1:0] value_reg, value_next;   // radicand
    logic [EXP_W-1:0]      exp_reg, exp_next;       // root degree
    logic [VALUE_BITS-1:0] root_reg, root_next;     // bits settled so far
    logic [BIT_W-1:0]      bit_reg, bit_next;       // bit under test
    logic [VALUE_BITS-1:0] acc_reg, acc_next;       // partial power of the candidate
    logic [EXP_W-1:0]      cnt_reg, cnt_next;       // multiplies done for this candidate
    logic [PROD_W-1:0]     prod_reg, prod_next;     // registered multiplier result
    logic                  bad_reg, bad_next;       // zero exponent seen

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [ROOT_W-1:0]     out_root_reg, out_root_next;
    logic                  out_bad_reg, out_bad_next;

    logic [VALUE_BITS-1:0] cand;
    logic [VALUE_BITS-1:0] in_value;
    logic [EXP_W-1:0]      in_exp;
    logic                  in_xfer;
    logic                  out_load;

    assign in_value = s_axis_tdata[VALUE_BITS-1:0];
    assign in_exp   = s_axis_tdata[ROOT_W +: EXP_W];

    // candidate: settled bits plus the bit under test
    assign cand = root_reg | (VALUE_BITS'(1) << bit_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // result moves to the output register once that register is free or being drained
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        exp_reg      <= exp_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        acc_reg      <= acc_next;
        cnt_reg      <= cnt_next;
        prod_reg     <= prod_next;
        bad_reg      <= bad_next;
        out_root_reg <= out_root_next;
        out_bad_reg  <= out_bad_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        value_next    = value_reg;
        exp_next      = exp_reg;
        root_next     = root_reg;
        bit_next      = bit_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        prod_next     = prod_reg;
        bad_next      = bad_reg;
        out_root_next = out_root_reg;
        out_bad_next  = out_bad_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    value_next = in_value;
                    exp_next   = in_exp;
                    root_next  = '0;
                    bit_next   = BIT_W'(VALUE_BITS - 1);
                    acc_next   = VALUE_BITS'(1);
                    cnt_next   = '0;
                    bad_next   = (in_exp == '0);
                    if (in_exp == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if ({1'b0, in_exp} >= (EXP_W + 1)'(VALUE_BITS))
                    begin
                        // even 2 to this power exceeds every value
                        root_next  = VALUE_BITS'(in_value != '0);
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(acc_reg) * PROD_W'(cand);
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (prod_reg > PROD_W'(value_reg))
                begin
                    // power already too big, bit stays clear
                    state_next = ST_NEXT;
                end
                else if (cnt_reg + EXP_W'(1) == exp_reg)
                begin
                    root_next  = cand;
                    state_next = ST_NEXT;
                end
                else
                begin
                    acc_next   = prod_reg[VALUE_BITS-1:0];
                    cnt_next   = cnt_reg + EXP_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_NEXT:
            begin
                acc_next = VALUE_BITS'(1);
                cnt_next = '0;
                if (bit_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    bit_next   = bit_reg - BIT_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    out_root_next = ROOT_W'(root_reg);
                    out_bad_next  = bad_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_axis_tready;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_root_reg;
    assign m_axis_tuser  = out_bad_reg;

endmodule

// ===== hw/rtl/inr_checker.sv =====
// port-level checker for the integer nth root block, bound to the top level
module inr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [inr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [inr_pkg::ROOT_W-1:0]    m_axis_tdata,
    input logic                          m_axis_tuser
);
    import inr_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // a flagged exponent always comes with a zero root
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("bad exponent with nonzero root");

    // one item at a time: input closes right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still open after a transfer");

endmodule

bind integer_nth_root_top inr_checker u_inr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/integer_nth_root_top_tb.sv =====
// self-checking stream testbench for the integer nth root block
module integer_nth_root_top_tb;

    import inr_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int IDLE_PERCENT   = 27;
    localparam int MAX_REPORTS    = 10;
    // limit on cycles without a transfer, about twenty times the slowest item
    localparam int WATCHDOG_LIMIT = 40000;
    // drain time after the last result, about twice the slowest item
    localparam int DRAIN_CYCLES   = 4200;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              bad_exponent;
    } root_result_t;

    // expected roots in arrival order, with an exact power search as predictor
    class root_scoreboard;
        root_result_t pending_roots[$];
        int           mismatches;

        function new();
            mismatches = 0;
        endfunction

        // exact test of cand^e <= limit, stopping at the first product above limit
        function bit power_within(longint unsigned cand, int e, longint unsigned limit);
            longint unsigned acc;
            acc = 1;
            for (int i = 0; i < e; i++) begin
                // acc and cand are both below 2^32, so the product cannot wrap
                if (acc * cand > limit)
                    return 1'b0;
                acc = acc * cand;
            end
            return 1'b1;
        endfunction

        function root_result_t predict(logic [VALUE_BITS-1:0] value, logic [EXP_W-1:0] exponent);
            root_result_t    res;
            longint unsigned cand;
            longint unsigned found;
            res   = '0;
            found = 0;
            if (exponent == '0) begin
                res.bad_exponent = 1'b1;
                return res;
            end
            // build the root from the top bit down, keeping each bit whose power fits
            for (int b = VALUE_BITS - 1; b >= 0; b--) begin
                cand = found | (64'd1 << b);
                if (power_within(cand, int'(exponent), longint'(value)))
                    found = cand;
            end
            res.root = found[ROOT_W-1:0];
            return res;
        endfunction

        function void note_input(logic [VALUE_BITS-1:0] value, logic [EXP_W-1:0] exponent);
            pending_roots.push_back(predict(value, exponent));
        endfunction

        function void check_result(logic [ROOT_W-1:0] root, logic bad_exponent);
            root_result_t want;
            if (pending_roots.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: root %0d bad_exponent %0b", root, bad_exponent);
                return;
            end
            want = pending_roots.pop_front();
            if (root !== want.root || bad_exponent !== want.bad_exponent) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    if (root !== want.root)
                        $display("root mismatch: expected %0d actual %0d", want.root, root);
                    if (bad_exponent !== want.bad_exponent)
                        $display("bad_exponent mismatch: expected %0b actual %0b",
                                 want.bad_exponent, bad_exponent);
                end
            end
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [ROOT_W-1:0]     m_axis_tdata;
    logic                  m_axis_tuser;

    root_scoreboard roots;
    bit             steady      = 1'b0;  // no idling on either side while set
    int             quiet_cycles = 0;

    integer_nth_root_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // value[31:0], exponent[37:32], zero pad
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // root[31:0]
        .m_axis_tuser  (m_axis_tuser)    // bad_exponent
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    // present one radicand and exponent, hold it until the transfer happens
    task automatic send_root_request(input logic [VALUE_BITS-1:0] value,
                                     input logic [EXP_W-1:0]      exponent);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[VALUE_BITS-1:0]                = value;
        word[VALUE_BITS +: EXP_W]           = exponent;
        // random gaps with valid low before the item
        while (take_break()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        roots.note_input(value, exponent);
    endtask

    // radicand near a perfect power, which is where an off-by-one would show
    task automatic send_near_power(input logic [EXP_W-1:0] exponent);
        root_result_t    top_res;
        longint unsigned m_top;
        longint unsigned m;
        longint unsigned pw;
        int              shift;
        top_res = roots.predict('1, exponent);
        m_top   = longint'(top_res.root);
        m     = (m_top > 64'hFFFF_FFFE) ? longint'($urandom_range(1, 32'hFFFF_FFFF))
                                        : longint'($urandom_range(1, int'(m_top)));
        pw    = 1;
        for (int i = 0; i < exponent; i++)
            pw = pw * m;
        shift = $urandom_range(0, 2);
        if (shift == 0 && pw > 0)
            pw = pw - 1;
        else if (shift == 2 && pw < 64'hFFFF_FFFF)
            pw = pw + 1;
        send_root_request(pw[VALUE_BITS-1:0], exponent);
    endtask

    // results side: check every transfer, stall at random
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                roots.check_result(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= !take_break();
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("integer_nth_root_top test failed");
                $finish;
            end
            else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int                    pick;
        logic [EXP_W-1:0]      exponent;
        logic [VALUE_BITS-1:0] value;
        roots = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero exponent, exponent one, large exponents, field extremes
        send_root_request(32'd0,          6'd0);
        send_root_request(32'hFFFF_FFFF,  6'd0);
        send_root_request(32'h1234_5678,  6'd0);
        send_root_request(32'd0,          6'd1);
        send_root_request(32'd1,          6'd1);
        send_root_request(32'hFFFF_FFFF,  6'd1);
        send_root_request(32'd123456789,  6'd1);
        send_root_request(32'd0,          6'd2);
        send_root_request(32'd2,          6'd2);
        send_root_request(32'hFFFF_FFFF,  6'd2);
        send_root_request(32'hFFFE_0001,  6'd2);   // exactly 65535 squared
        send_root_request(32'hFFFE_0000,  6'd2);
        send_root_request(32'hFFFF_FFFF,  6'd3);
        send_root_request(32'd1000000,    6'd6);
        send_root_request(32'd999999,     6'd6);
        send_root_request(32'd3486784401, 6'd20);  // 3 to the 20th
        send_root_request(32'd3486784400, 6'd20);
        send_root_request(32'h8000_0000,  6'd31);
        send_root_request(32'h7FFF_FFFF,  6'd31);
        send_root_request(32'hFFFF_FFFF,  6'd31);
        send_root_request(32'd0,          6'd32);
        send_root_request(32'd1,          6'd32);
        send_root_request(32'hFFFF_FFFF,  6'd32);
        send_root_request(32'd0,          6'd63);
        send_root_request(32'd5,          6'd63);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 700 && n < 900);
            pick   = $urandom_range(0, 99);
            // mostly meaningful degrees, some zero and some beyond the radicand width
            if (pick < 5)
                exponent = '0;
            else if (pick < 13)
                exponent = EXP_W'($urandom_range(32, 63));
            else if (pick < 40)
                exponent = EXP_W'($urandom_range(1, 4));
            else
                exponent = EXP_W'($urandom_range(1, 31));
            pick = $urandom_range(0, 99);
            if (pick < 40 && exponent != '0 && exponent < 32) begin
                send_near_power(exponent);
            end
            else begin
                if (pick < 65)
                    value = $urandom();
                else if (pick < 80)
                    value = VALUE_BITS'($urandom_range(0, 1023));
                else if (pick < 90)
                    value = $urandom() >> $urandom_range(0, 31);
                else
                    value = (32'd1 << $urandom_range(0, 31)) - VALUE_BITS'($urandom_range(0, 1));
                send_root_request(value, exponent);
            end
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        // drain, then give a stray result time to show up
        while (roots.pending_roots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (roots.mismatches == 0 && roots.pending_roots.size() == 0)
            $display("integer_nth_root_top test passed");
        else
            $display("integer_nth_root_top test failed");
        $finish;
    end

endmodule
